// ===== rtl/swhs_pkg.sv =====
// shared types and constants for the single-wire humidity sensor reader
// no dependencies; imported by swhs_engine and the reader top level
package swhs_pkg;

    localparam int FRAME_BITS    = 40;
    localparam int BIT_IDX_W     = 6;
    localparam int CNT_W_DEF     = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SAMPLE = 2'd2;

    localparam logic [15:0] START_LOW_RST  = 16'd30000;
    localparam logic [7:0]  RELEASE_RST    = 8'd20;
    localparam logic [7:0]  BIT_SAMPLE_RST = 8'd35;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       frame_done;
        logic [7:0] humid_int;
        logic [7:0] humid_frac;
        logic [7:0] temp_int;
        logic [7:0] temp_frac;
        logic [7:0] checksum_rx;
        logic       checksum_ok;
        logic [7:0] fail_count;
    } res_t;

    function automatic logic sum_ok(input logic [FRAME_BITS-1:0] bytes);
        logic [7:0] s;
        s = bytes[39:32] + bytes[31:24] + bytes[23:16] + bytes[15:8];
        return s == bytes[7:0];
    endfunction

endpackage

// ===== rtl/swhs_fifo.sv =====
// short register queue with registered storage, used on both sides of the engine
// depends on nothing but its parameters
module swhs_fifo #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/swhs_engine.sv =====
// protocol engine: start pulse, response tracking, bit timing and frame check
// depends on swhs_pkg; takes one tick word per cycle from the front queue while the back queue is not full
module swhs_engine
    import swhs_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  tick_valid,
    input  in_t                   tick,
    input  logic                  res_full,
    output logic                  tick_take,
    output res_t                  res
);
    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [BIT_IDX_W-1:0] LAST_BITS = BIT_IDX_W'(FRAME_BITS);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_RELEASE,
        PH_WAIT_RESP_LOW,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_BIT_RISE,
        PH_BIT_TIMING,
        PH_BIT_FALL
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]  tick_count_reg, tick_count_next, tick_inc;
    logic [BIT_IDX_W-1:0]    bit_index_reg, bit_index_next, bit_inc;
    logic [FRAME_BITS-1:0]   frame_shift_reg, frame_shift_next, shift_in;
    logic [FRAME_BITS-1:0]   held_reg, held_next;
    logic [7:0]              fail_reg, fail_next;
    logic [15:0]             start_low_reg;
    logic [7:0]              release_reg;
    logic [7:0]              bit_sample_reg;
    logic [CMP_W-1:0]        limit;
    logic                    reached;
    logic                    done;

    assign tick_take = tick_valid && !res_full;
    assign tick_inc  = (tick_count_reg != CNT_MAX) ? tick_count_reg + 1'b1 : tick_count_reg;
    assign bit_inc   = bit_index_reg + 1'b1;
    assign shift_in  = {frame_shift_reg[FRAME_BITS-2:0], tick.line_level};

    always_comb
    begin
        case (phase_reg)
            PH_START_LOW: limit = CMP_W'(start_low_reg);
            PH_RELEASE:   limit = CMP_W'(release_reg);
            default:      limit = CMP_W'(bit_sample_reg);
        endcase
    end

    assign reached = (CMP_W'(tick_inc) >= limit) || (tick_inc == CNT_MAX);

    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        frame_shift_next = frame_shift_reg;
        held_next        = held_reg;
        fail_next        = fail_reg;
        done             = 1'b0;
        case (phase_reg)
            PH_START_LOW:
            begin
                tick_count_next = tick_inc;
                if (reached)
                begin
                    phase_next      = PH_RELEASE;
                    tick_count_next = '0;
                end
            end
            PH_RELEASE:
            begin
                tick_count_next = tick_inc;
                if (reached)
                begin
                    phase_next      = PH_WAIT_RESP_LOW;
                    tick_count_next = '0;
                end
            end
            PH_WAIT_RESP_LOW:
            begin
                if (!tick.line_level)
                begin
                    phase_next = PH_RESP_LOW;
                end
            end
            PH_RESP_LOW:
            begin
                if (tick.line_level)
                begin
                    phase_next = PH_RESP_HIGH;
                end
            end
            PH_RESP_HIGH:
            begin
                if (!tick.line_level)
                begin
                    phase_next     = PH_BIT_RISE;
                    bit_index_next = '0;
                end
            end
            PH_BIT_RISE:
            begin
                if (tick.line_level)
                begin
                    phase_next      = PH_BIT_TIMING;
                    tick_count_next = '0;
                end
            end
            PH_BIT_TIMING:
            begin
                tick_count_next = tick_inc;
                if (reached)
                begin
                    tick_count_next  = '0;
                    frame_shift_next = shift_in;
                    if (bit_inc >= LAST_BITS)
                    begin
                        held_next      = shift_in;
                        done           = 1'b1;
                        fail_next      = sum_ok(shift_in) ? 8'd0 : fail_reg + 8'd1;
                        phase_next     = PH_IDLE;
                        bit_index_next = '0;
                    end
                    else
                    begin
                        bit_index_next = bit_inc;
                        phase_next     = tick.line_level ? PH_BIT_FALL : PH_BIT_RISE;
                    end
                end
            end
            PH_BIT_FALL:
            begin
                if (!tick.line_level)
                begin
                    phase_next = PH_BIT_RISE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (tick.start_req)
                begin
                    phase_next       = PH_START_LOW;
                    tick_count_next  = '0;
                    bit_index_next   = '0;
                    frame_shift_next = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        res.drive_low   = (phase_next == PH_START_LOW);
        res.busy_res    = (phase_next != PH_IDLE);
        res.frame_done  = done;
        res.humid_int   = held_next[39:32];
        res.humid_frac  = held_next[31:24];
        res.temp_int    = held_next[23:16];
        res.temp_frac   = held_next[15:8];
        res.checksum_rx = held_next[7:0];
        res.checksum_ok = sum_ok(held_next);
        res.fail_count  = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            frame_shift_reg <= '0;
            held_reg        <= '0;
            fail_reg        <= '0;
            start_low_reg   <= START_LOW_RST;
            release_reg     <= RELEASE_RST;
            bit_sample_reg  <= BIT_SAMPLE_RST;
        end
        else
        begin
            if (tick_take)
            begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                bit_index_reg   <= bit_index_next;
                frame_shift_reg <= frame_shift_next;
                held_reg        <= held_next;
                fail_reg        <= fail_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_LOW:  start_low_reg  <= cfg_data;
                    REG_RELEASE:    release_reg    <= cfg_data[7:0];
                    REG_BIT_SAMPLE: bit_sample_reg <= cfg_data[7:0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// single-wire humidity sensor reader: one result word per tick word
// a pushed word is held in the front queue; its result word is written to the back queue and popped from there
// throughput: one word per cycle while the back queue is not full; queues of DEPTH words
// asynchronous active-low reset: idle, all counters and held bytes zero,
// registers at their default values; no clearing pass
// depends on swhs_pkg, swhs_fifo and swhs_engine
module single_wire_humidity_sensor_reader
    import swhs_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEF,
    parameter int DEPTH       = QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  in_t                   item,
    output logic                  full,
    input  logic                  pop,
    output res_t                  result,
    output logic                  empty,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int IN_W  = $bits(in_t);
    localparam int RES_W = $bits(res_t);

    logic [IN_W-1:0]  in_q;
    logic [RES_W-1:0] res_q;
    logic             in_empty;
    logic             res_full;
    logic             tick_take;
    in_t              tick;
    res_t             res;

    assign tick   = in_t'(in_q);
    assign result = res_t'(res_q);

    swhs_fifo #(
        .WIDTH (IN_W),
        .DEPTH (DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .din   (IN_W'(item)),
        .full  (full),
        .rd    (tick_take),
        .dout  (in_q),
        .empty (in_empty)
    );

    swhs_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick_valid (!in_empty),
        .tick       (tick),
        .res_full   (res_full),
        .tick_take  (tick_take),
        .res        (res)
    );

    swhs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tick_take),
        .din   (RES_W'(res)),
        .full  (res_full),
        .rd    (pop),
        .dout  (res_q),
        .empty (empty)
    );

endmodule

// ===== tb/sv/single_wire_humidity_sensor_reader_tb.sv =====
// self-checking testbench for the single-wire humidity sensor reader
// drives sensor tick words through the push side and checks every result word
// against a word-by-word predictor; depends on swhs_pkg and the reader top level
module single_wire_humidity_sensor_reader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swhs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_WORDS = 1050;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_LOW,
        ST_RELEASE,
        ST_WAIT_RESP_LOW,
        ST_RESP_LOW,
        ST_RESP_HIGH,
        ST_BIT_RISE,
        ST_BIT_TIMING,
        ST_BIT_FALL
    } reader_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    in_t item = '0;
    logic full;
    logic pop = 1'b0;
    res_t result;
    logic empty;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and register copies
    reader_phase_t rd_phase = ST_IDLE;
    logic [15:0] rd_ticks = '0;
    logic [5:0] rd_bit = '0;
    logic [FRAME_BITS-1:0] rd_shift = '0;
    logic [FRAME_BITS-1:0] rd_held = '0;
    logic [7:0] rd_fails = '0;
    logic [15:0] low_cfg = START_LOW_RST;
    logic [7:0] rel_cfg = RELEASE_RST;
    logic [7:0] sample_cfg = BIT_SAMPLE_RST;

    in_t tick_words[$];
    res_t expected_readings[$];

    bit rush = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int words_queued = 0;
    int random_words = 0;
    int frames_done = 0;
    int sums_bad = 0;

    single_wire_humidity_sensor_reader u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        if (rush)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic int eff_ticks(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic bit count_reached(input logic [15:0] lim);
        if (rd_ticks != TICK_MAX)
            rd_ticks = rd_ticks + 16'd1;
        return (rd_ticks >= lim) || (rd_ticks == TICK_MAX);
    endfunction

    function automatic bit held_sum_matches();
        return 8'(rd_held[39:32] + rd_held[31:24] + rd_held[23:16] + rd_held[15:8])
            == rd_held[7:0];
    endfunction

    function automatic res_t advance_reader(input in_t w);
        res_t r;
        bit done;
        done = 1'b0;
        case (rd_phase)
            ST_START_LOW:
                if (count_reached(low_cfg))
                begin
                    rd_phase = ST_RELEASE;
                    rd_ticks = '0;
                end
            ST_RELEASE:
                if (count_reached({8'd0, rel_cfg}))
                begin
                    rd_phase = ST_WAIT_RESP_LOW;
                    rd_ticks = '0;
                end
            ST_WAIT_RESP_LOW:
                if (!w.line_level)
                    rd_phase = ST_RESP_LOW;
            ST_RESP_LOW:
                if (w.line_level)
                    rd_phase = ST_RESP_HIGH;
            ST_RESP_HIGH:
                if (!w.line_level)
                begin
                    rd_phase = ST_BIT_RISE;
                    rd_bit = '0;
                end
            ST_BIT_RISE:
                if (w.line_level)
                begin
                    rd_phase = ST_BIT_TIMING;
                    rd_ticks = '0;
                end
            ST_BIT_TIMING:
                if (count_reached({8'd0, sample_cfg}))
                begin
                    rd_ticks = '0;
                    rd_shift = {rd_shift[FRAME_BITS-2:0], w.line_level};
                    rd_bit = rd_bit + 6'd1;
                    if (rd_bit >= FRAME_BITS)
                    begin
                        rd_held = rd_shift;
                        done = 1'b1;
                        frames_done++;
                        if (held_sum_matches())
                            rd_fails = '0;
                        else
                        begin
                            rd_fails = rd_fails + 8'd1;
                            sums_bad++;
                        end
                        rd_phase = ST_IDLE;
                        rd_bit = '0;
                    end
                    else
                        rd_phase = w.line_level ? ST_BIT_FALL : ST_BIT_RISE;
                end
            ST_BIT_FALL:
                if (!w.line_level)
                    rd_phase = ST_BIT_RISE;
            default:
            begin
                rd_phase = ST_IDLE;
                if (w.start_req)
                begin
                    rd_phase = ST_START_LOW;
                    rd_ticks = '0;
                    rd_bit = '0;
                    rd_shift = '0;
                end
            end
        endcase
        r.drive_low = (rd_phase == ST_START_LOW);
        r.busy_res = (rd_phase != ST_IDLE);
        r.frame_done = done;
        r.humid_int = rd_held[39:32];
        r.humid_frac = rd_held[31:24];
        r.temp_int = rd_held[23:16];
        r.temp_frac = rd_held[15:8];
        r.checksum_rx = rd_held[7:0];
        r.checksum_ok = held_sum_matches();
        r.fail_count = rd_fails;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result word %0d %s: got %0h, expected %0h",
                                      words_out, name, got, want));
    endtask

    task automatic check_reading(input res_t got);
        res_t want;
        if (expected_readings.size() == 0)
            report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                      words_out));
        else
        begin
            want = expected_readings.pop_front();
            check_field("drive_low", 8'(got.drive_low), 8'(want.drive_low));
            check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            check_field("frame_done", 8'(got.frame_done), 8'(want.frame_done));
            check_field("humid_int", got.humid_int, want.humid_int);
            check_field("humid_frac", got.humid_frac, want.humid_frac);
            check_field("temp_int", got.temp_int, want.temp_int);
            check_field("temp_frac", got.temp_frac, want.temp_frac);
            check_field("checksum_rx", got.checksum_rx, want.checksum_rx);
            check_field("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
            check_field("fail_count", got.fail_count, want.fail_count);
        end
        words_out++;
    endtask

    // driver: one tick word per push, random gap after each
    always @(posedge clk)
    begin : driver
        if (!rst_n)
        begin
            push <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_readings.push_back(advance_reader(item));
                words_in++;
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    push <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (tick_words.size() > 0)
                begin
                    item <= tick_words.pop_front();
                    push <= 1'b1;
                    gap_left <= draw_wait();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: pops result words with random stalls
    always @(posedge clk)
    begin : monitor
        int w;
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left <= 0;
        end
        else if (pop && !empty)
        begin
            check_reading(result);
            w = draw_wait();
            stall_left <= w;
            pop <= (w == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pop <= (stall_left == 1);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic void queue_tick(input bit start, input bit line, input bit counted);
        in_t w;
        w.start_req = start;
        w.line_level = line;
        tick_words.push_back(w);
        words_queued++;
        if (counted)
            random_words++;
    endfunction

    function automatic bit stray_start();
        return $urandom_range(0, 7) == 0;
    endfunction

    function automatic logic [39:0] make_frame(input bit good);
        logic [7:0] a, b, c, d, cs;
        a = 8'($urandom);
        b = 8'($urandom);
        c = 8'($urandom);
        d = 8'($urandom);
        cs = a + b + c + d;
        if (!good)
            cs = cs + 8'($urandom_range(1, 255));
        return {a, b, c, d, cs};
    endfunction

    task automatic wait_quiet();
        while (tick_words.size() != 0 || push || expected_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_LOW: low_cfg = data;
            REG_RELEASE: rel_cfg = data[7:0];
            REG_BIT_SAMPLE: sample_cfg = data[7:0];
            default: ;
        endcase
    endtask

    // sensor waveform for one complete reading, starting from idle
    task automatic send_frame(input logic [39:0] data, input bit counted);
        int sl, rl, s, h, lo, k;
        sl = eff_ticks(int'(low_cfg));
        rl = eff_ticks(int'(rel_cfg));
        s = eff_ticks(int'(sample_cfg));
        queue_tick(1'b1, 1'($urandom_range(0, 1)), counted);
        for (k = 0; k < sl + rl; k++)
            queue_tick(stray_start(), 1'($urandom_range(0, 1)), counted);
        repeat ($urandom_range(0, 3)) queue_tick(stray_start(), 1'b1, counted);
        repeat ($urandom_range(1, 4)) queue_tick(stray_start(), 1'b0, counted);
        repeat ($urandom_range(1, 4)) queue_tick(stray_start(), 1'b1, counted);
        lo = 1;
        for (k = FRAME_BITS - 1; k >= 0; k--)
        begin
            repeat (lo + $urandom_range(0, 2)) queue_tick(stray_start(), 1'b0, counted);
            if (data[k])
            begin
                h = s + 1 + $urandom_range(0, 2);
                lo = 1;
            end
            else
            begin
                h = $urandom_range(1, s);
                lo = s - h + 1;
            end
            repeat (h) queue_tick((k > 0) ? stray_start() : 1'b0, 1'b1, counted);
        end
        repeat (lo + $urandom_range(0, 2)) queue_tick(1'b0, 1'b0, counted);
    endtask

    // feed well-timed bit pulses until the reader is back in idle
    task automatic settle_reader();
        int s;
        wait_quiet();
        while (rd_phase != ST_IDLE)
        begin
            s = eff_ticks(int'(sample_cfg));
            repeat (2) queue_tick(1'b0, 1'b0, 1'b0);
            repeat (s + 1) queue_tick(1'b0, 1'b1, 1'b0);
            wait_quiet();
        end
    endtask

    task automatic send_broken(input bit counted);
        queue_tick(1'b1, 1'($urandom_range(0, 1)), counted);
        repeat ($urandom_range(10, 150))
            queue_tick(stray_start(), 1'($urandom_range(0, 1)), counted);
        settle_reader();
    endtask

    task automatic shuffle_timing();
        settle_reader();
        write_reg(REG_START_LOW,
                  ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 8)));
        write_reg(REG_RELEASE, {8'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 6))});
        write_reg(REG_BIT_SAMPLE, {8'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 5))});
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // idle words at reset timing
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);
        wait_quiet();

        // shortest timing, byte extremes, checksum good and bad
        write_reg(REG_START_LOW, 16'd1);
        write_reg(REG_RELEASE, 16'hA501);
        write_reg(REG_BIT_SAMPLE, 16'h5A01);
        send_frame(40'h00_00_00_00_00, 1'b0);
        send_frame(40'hFF_FF_FF_FF_FF, 1'b0);
        send_frame(40'h80_7F_01_00_00, 1'b0);
        send_broken(1'b0);
        wait_quiet();

        // zero timing values behave as one
        write_reg(REG_START_LOW, 16'd0);
        write_reg(REG_RELEASE, 16'hFF00);
        write_reg(REG_BIT_SAMPLE, 16'hFF00);
        send_frame(make_frame(1'b0), 1'b0);
        wait_quiet();
        write_reg(REG_UNUSED, 16'($urandom));

        shuffle_timing();
        while (words_queued < TOTAL_WORDS)
        begin
            if ($urandom_range(0, 3) == 0)
                shuffle_timing();
            rush = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(5, 30))
                       queue_tick(1'b0, 1'($urandom_range(0, 1)), 1'b1);
                1: send_broken(1'b1);
                default: send_frame(make_frame(1'($urandom_range(0, 1))), 1'b1);
            endcase
        end
        rush = 1'b0;
        wait_quiet();
        repeat (10) @(posedge clk);

        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d expected result words never arrived",
                                      expected_readings.size()));
        $display("run covered %0d tick words (%0d in random readings) and %0d result words",
                 words_in, random_words, words_out);
        $display("%0d frames decoded, %0d with a bad checksum, %0d mismatches",
                 frames_done, sums_bad, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
